@@ sv/lsmp_pkg.sv @@
// lsmp_pkg: shared constants, step codes and handshake types of the lens move planner
package lsmp_pkg;

  localparam int DIV_W = 20;
  localparam int CNT_W = $clog2(DIV_W);
  localparam int UOP_W = 6;
  localparam int IN_DW = 40;
  localparam int OUT_DW = 40;

  localparam int K_ZOOM = 140625;
  localparam int K_FOCUS = 281250;
  localparam int K_PSUM = 11250;
  localparam logic [15:0] RATE_MIN = 16'd100;
  localparam logic [15:0] RATE_MAX = 16'd3000;

  localparam logic [5:0] ADDR_ZCTL = 6'h24;
  localparam logic [5:0] ADDR_ZSPD = 6'h25;
  localparam logic [5:0] ADDR_FCTL = 6'h29;
  localparam logic [5:0] ADDR_FSPD = 6'h2a;
  localparam logic [15:0] CTL_RESET = 16'h1800;
  localparam logic [15:0] HI_MASK = 16'hff00;
  localparam logic [15:0] EN_BIT = 16'h0400;
  localparam logic [15:0] MODE_MASK = 16'h0b00;

  localparam logic [1:0] ACT_SPEED = 2'd0;
  localparam logic [1:0] ACT_MODE = 2'd1;
  localparam logic [1:0] ACT_MOVE = 2'd2;
  localparam logic [1:0] ACT_SYNC = 2'd3;

  // sequencer steps: idle, decode, divisions, then result transactions
  localparam logic [UOP_W-1:0] U_IDLE = 6'd0;
  localparam logic [UOP_W-1:0] U_DEC  = 6'd1;
  localparam logic [UOP_W-1:0] U_IV0  = 6'd2;
  localparam logic [UOP_W-1:0] U_PS0  = 6'd3;
  localparam logic [UOP_W-1:0] U_IV1  = 6'd4;
  localparam logic [UOP_W-1:0] U_PSM  = 6'd5;
  localparam logic [UOP_W-1:0] U_MV   = 6'd6;
  localparam logic [UOP_W-1:0] U_ZPS  = 6'd7;
  localparam logic [UOP_W-1:0] U_FPS  = 6'd8;
  localparam logic [UOP_W-1:0] U_ZV   = 6'd9;
  localparam logic [UOP_W-1:0] U_FV   = 6'd10;
  localparam logic [UOP_W-1:0] U_FZ   = 6'd11;
  localparam logic [UOP_W-1:0] U_ZF   = 6'd12;
  localparam logic [UOP_W-1:0] U_SPD  = 6'd13;
  localparam logic [UOP_W-1:0] U_MODE = 6'd14;
  localparam logic [UOP_W-1:0] U_EN   = 6'd15;
  localparam logic [UOP_W-1:0] U_LPS  = 6'd16;
  localparam logic [UOP_W-1:0] U_BQA  = 6'd17;
  localparam logic [UOP_W-1:0] U_LRA  = 6'd18;
  localparam logic [UOP_W-1:0] U_B1   = 6'd19;
  localparam logic [UOP_W-1:0] U_L0   = 6'd20;
  localparam logic [UOP_W-1:0] U_DIS  = 6'd21;
  localparam logic [UOP_W-1:0] U_ZEN  = 6'd22;
  localparam logic [UOP_W-1:0] U_FEN  = 6'd23;
  localparam logic [UOP_W-1:0] U_ZLPS = 6'd24;
  localparam logic [UOP_W-1:0] U_FLQ  = 6'd25;
  localparam logic [UOP_W-1:0] U_FLPS = 6'd26;
  localparam logic [UOP_W-1:0] U_ZLQ  = 6'd27;
  localparam logic [UOP_W-1:0] U_BQB  = 6'd28;
  localparam logic [UOP_W-1:0] U_ZLR  = 6'd29;
  localparam logic [UOP_W-1:0] U_FLR  = 6'd30;
  localparam logic [UOP_W-1:0] U_ZL0  = 6'd31;
  localparam logic [UOP_W-1:0] U_FL0  = 6'd32;
  localparam logic [UOP_W-1:0] U_ZDIS = 6'd33;
  localparam logic [UOP_W-1:0] U_FDIS = 6'd34;

  typedef struct packed {
    logic             load;
    logic             div_start;
    logic             emit;
    logic [UOP_W-1:0] uop;
  } lsmp_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       out_free;
    logic [1:0] act;
    logic       mv_skip;
    logic       sync_skip;
    logic       qa_nz;
    logic       ra_nz;
    logic       zv_gt_fv;
    logic       both_zero;
    logic       rem_nz;
  } lsmp_sts_t;

  function automatic logic [15:0] set_low(input logic [15:0] r, input logic [7:0] low);
    set_low = (r & HI_MASK) | {8'h00, low};
  endfunction

endpackage

@@ sv/lens_stepper_move_planner.sv @@
// lens_stepper_move_planner: top level of the zoom and focus lens move planner
//
//  channel  ports                          payload
//  in       in_tvalid/in_tready/in_tdata   tuser action, tdata motor..sensor_enable
//  out      out_tvalid/out_tready/out_tdata tuser kind, tlast last, tdata addr/data/count
//
// one command at a time; a serial divider sets the pace
// reset restores both control words to 0x1800 and clears both speeds
// a stalled output holds the sequencer before its next result, the input waits until idle
module lens_stepper_move_planner (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // motor[0], amount[16:1], focus_amount[32:17], reverse[33], brake[34],
  // sensor_enable[35], zero[39:36]
  input  logic [lsmp_pkg::IN_DW-1:0]   in_tdata,
  // action[1:0]
  input  logic [1:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // reg_address[5:0], reg_data[21:6], pulse_count[37:22], zero[39:38]
  output logic [lsmp_pkg::OUT_DW-1:0]  out_tdata,
  // kind[0]
  output logic                        out_tuser,
  output logic                        out_tlast
);
  import lsmp_pkg::*;

  lsmp_cmd_t cmd;
  lsmp_sts_t sts;

  lsmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsmp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ sv/lsmp_div.sv @@
// lsmp_div: serial restoring divider, one quotient bit per cycle
module lsmp_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lsmp_pkg::DIV_W-1:0] dividend,
  input  logic [lsmp_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [lsmp_pkg::DIV_W-1:0] quot,
  output logic [lsmp_pkg::DIV_W-1:0] rem
);
  import lsmp_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] dvs_r;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[DIV_W-2:0], ge};
        rem_r <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

@@ sv/lsmp_dp.sv @@
// lsmp_dp: datapath with command latch, motor state, divider operands and output register
module lsmp_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lsmp_pkg::IN_DW-1:0]  in_tdata,
  input  logic [1:0]                 in_tuser,
  input  lsmp_pkg::lsmp_cmd_t        cmd,
  output lsmp_pkg::lsmp_sts_t        sts,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [lsmp_pkg::OUT_DW-1:0] out_tdata,
  output logic                       out_tuser,
  output logic                       out_tlast
);
  import lsmp_pkg::*;

  localparam logic [1:0] CM_LOW  = 2'd0;
  localparam logic [1:0] CM_EN   = 2'd1;
  localparam logic [1:0] CM_DIS  = 2'd2;
  localparam logic [1:0] CM_MODE = 2'd3;

  logic [1:0]       act_r;
  logic             mot_r;
  logic [15:0]      amt_r;
  logic [15:0]      famt_r;
  logic             rev_r;
  logic             brk_r;
  logic             sen_r;
  logic [15:0]      zctl_r;
  logic [15:0]      fctl_r;
  logic [11:0]      zivl_r;
  logic [11:0]      fivl_r;
  logic [DIV_W-1:0] tq_r;
  logic [DIV_W-1:0] qa_r;
  logic [DIV_W-1:0] qb_r;
  logic [7:0]       pa_r;
  logic [7:0]       pb_r;
  logic [7:0]       ra_r;
  logic [7:0]       rb_r;
  logic             out_valid_r;
  logic [OUT_DW-1:0] out_data_r;
  logic             out_kind_r;
  logic             out_last_r;

  logic [15:0]      rate_c;
  logic [11:0]      ivl_m;
  logic [DIV_W-1:0] zmic;
  logic [DIV_W-1:0] fmic;
  logic [DIV_W-1:0] mmic;
  logic [DIV_W-1:0] dvd;
  logic [DIV_W-1:0] dvs;
  logic             div_done;
  logic [DIV_W-1:0] quot;
  logic [DIV_W-1:0] rem;

  logic             e_burst;
  logic             e_spd;
  logic             e_tgt_f;
  logic [1:0]       e_mode;
  logic [7:0]       e_low;
  logic [15:0]      e_cnt;
  logic             e_last;
  logic [15:0]      ctl_cur;
  logic [15:0]      ctl_new;
  logic [5:0]       o_addr;
  logic [15:0]      o_data;
  logic [15:0]      o_cnt;

  assign rate_c = (amt_r < RATE_MIN) ? RATE_MIN : ((amt_r > RATE_MAX) ? RATE_MAX : amt_r);
  assign ivl_m  = mot_r ? fivl_r : zivl_r;
  assign zmic   = {1'b0, amt_r, 3'b000};
  assign fmic   = {2'b00, famt_r, 2'b00};
  assign mmic   = mot_r ? {2'b00, amt_r, 2'b00} : zmic;

  always_comb begin
    dvd = DIV_W'(K_PSUM);
    dvs = '0;
    unique case (cmd.uop)
      U_IV0: begin
        dvd = mot_r ? DIV_W'(K_FOCUS) : DIV_W'(K_ZOOM);
        dvs = DIV_W'(rate_c);
      end
      U_PS0: dvs = tq_r;
      U_IV1: dvs = DIV_W'(tq_r[7:0]);
      U_PSM: dvs = DIV_W'(ivl_m);
      U_MV: begin
        dvd = mmic;
        dvs = DIV_W'(pa_r);
      end
      U_ZPS: dvs = DIV_W'(zivl_r);
      U_FPS: dvs = DIV_W'(fivl_r);
      U_ZV: begin
        dvd = zmic;
        dvs = DIV_W'(pa_r);
      end
      U_FV: begin
        dvd = fmic;
        dvs = DIV_W'(pb_r);
      end
      U_FZ: begin
        dvd = fmic;
        dvs = qa_r;
      end
      U_ZF: begin
        dvd = zmic;
        dvs = qb_r;
      end
      default: dvs = '0;
    endcase
  end

  lsmp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  always_comb begin
    e_burst = 1'b0;
    e_spd   = 1'b0;
    e_tgt_f = mot_r;
    e_mode  = CM_LOW;
    e_low   = 8'h00;
    e_cnt   = 16'd0;
    e_last  = 1'b0;
    unique case (cmd.uop)
      U_SPD: begin
        e_spd  = 1'b1;
        e_last = 1'b1;
      end
      U_MODE: begin
        e_mode = CM_MODE;
        e_last = 1'b1;
      end
      U_EN:  e_mode = CM_EN;
      U_LPS: e_low = pa_r;
      U_LRA: e_low = ra_r;
      U_L0:  e_low = 8'h00;
      U_DIS: begin
        e_mode = CM_DIS;
        e_last = 1'b1;
      end
      U_BQA: begin
        e_burst = 1'b1;
        e_cnt   = qa_r[15:0];
      end
      U_BQB: begin
        e_burst = 1'b1;
        e_cnt   = qb_r[15:0];
      end
      U_B1: begin
        e_burst = 1'b1;
        e_cnt   = 16'd1;
      end
      U_ZEN: begin
        e_tgt_f = 1'b0;
        e_mode  = CM_EN;
      end
      U_FEN: begin
        e_tgt_f = 1'b1;
        e_mode  = CM_EN;
      end
      U_ZLPS: begin
        e_tgt_f = 1'b0;
        e_low   = pa_r;
      end
      U_FLQ: begin
        e_tgt_f = 1'b1;
        e_low   = tq_r[7:0];
      end
      U_FLPS: begin
        e_tgt_f = 1'b1;
        e_low   = pb_r;
      end
      U_ZLQ: begin
        e_tgt_f = 1'b0;
        e_low   = tq_r[7:0];
      end
      U_ZLR: begin
        e_tgt_f = 1'b0;
        e_low   = ra_r;
      end
      U_FLR: begin
        e_tgt_f = 1'b1;
        e_low   = rb_r;
      end
      U_ZL0: e_tgt_f = 1'b0;
      U_FL0: e_tgt_f = 1'b1;
      U_ZDIS: begin
        e_tgt_f = 1'b0;
        e_mode  = CM_DIS;
      end
      U_FDIS: begin
        e_tgt_f = 1'b1;
        e_mode  = CM_DIS;
        e_last  = 1'b1;
      end
      default: e_mode = CM_LOW;
    endcase
  end

  assign ctl_cur = e_tgt_f ? fctl_r : zctl_r;

  always_comb begin
    unique case (e_mode)
      CM_EN:   ctl_new = ctl_cur | EN_BIT;
      CM_DIS:  ctl_new = ctl_cur & ~EN_BIT;
      CM_MODE: ctl_new = (ctl_cur & ~MODE_MASK) |
                         {4'b0000, sen_r, 1'b0, brk_r, rev_r, 8'h00};
      default: ctl_new = set_low(ctl_cur, e_low);
    endcase
  end

  always_comb begin
    o_addr = e_tgt_f ? ADDR_FCTL : ADDR_ZCTL;
    o_data = ctl_new;
    o_cnt  = 16'd0;
    if (e_spd) begin
      o_addr = mot_r ? ADDR_FSPD : ADDR_ZSPD;
      o_data = {4'b0000, ivl_m};
    end else if (e_burst) begin
      o_addr = 6'd0;
      o_data = 16'd0;
      o_cnt  = e_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zctl_r      <= CTL_RESET;
      fctl_r      <= CTL_RESET;
      zivl_r      <= '0;
      fivl_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        act_r  <= in_tuser;
        mot_r  <= in_tdata[0];
        amt_r  <= in_tdata[16:1];
        famt_r <= in_tdata[32:17];
        rev_r  <= in_tdata[33];
        brk_r  <= in_tdata[34];
        sen_r  <= in_tdata[35];
      end
      if (div_done) begin
        unique case (cmd.uop)
          U_IV0, U_PS0: tq_r <= quot;
          U_IV1: begin
            if (mot_r) fivl_r <= quot[11:0];
            else zivl_r <= quot[11:0];
          end
          U_PSM, U_ZPS: pa_r <= quot[7:0];
          U_FPS: pb_r <= quot[7:0];
          U_MV, U_ZV: begin
            qa_r <= quot;
            ra_r <= rem[7:0];
          end
          U_FV: begin
            qb_r <= quot;
            rb_r <= rem[7:0];
          end
          U_FZ: begin
            tq_r <= quot;
            rb_r <= rem[7:0];
          end
          U_ZF: begin
            tq_r <= quot;
            ra_r <= rem[7:0];
          end
          default: tq_r <= tq_r;
        endcase
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {2'b00, o_cnt, o_data, o_addr};
        out_kind_r  <= e_burst;
        out_last_r  <= e_last;
        if (!e_burst && !e_spd) begin
          if (e_tgt_f) fctl_r <= ctl_new;
          else zctl_r <= ctl_new;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.act       = act_r;
  assign sts.mv_skip   = (amt_r == 16'd0) || (ivl_m == 12'd0);
  assign sts.sync_skip = (zivl_r == 12'd0) || (fivl_r == 12'd0) ||
                         ((amt_r == 16'd0) && (famt_r == 16'd0));
  assign sts.qa_nz     = qa_r != '0;
  assign sts.ra_nz     = ra_r != 8'h00;
  assign sts.zv_gt_fv  = qa_r > qb_r;
  assign sts.both_zero = (qa_r == '0) && (qb_r == '0);
  assign sts.rem_nz    = (ra_r != 8'h00) || (rb_r != 8'h00);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

@@ sv/lsmp_ctrl.sv @@
// lsmp_ctrl: step sequencer that orders divisions and result transactions per command
module lsmp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  lsmp_pkg::lsmp_sts_t sts,
  output lsmp_pkg::lsmp_cmd_t cmd
);
  import lsmp_pkg::*;

  logic [UOP_W-1:0] state_r;
  logic [UOP_W-1:0] state_nxt;
  logic [UOP_W-1:0] follow;
  logic             started_r;
  logic             started_nxt;
  logic             is_div;
  logic             sync;

  assign is_div = (state_r >= U_IV0) && (state_r <= U_ZF);
  assign sync   = sts.act == ACT_SYNC;

  always_comb begin
    unique case (state_r)
      U_IDLE: follow = U_DEC;
      U_DEC: begin
        unique case (sts.act)
          ACT_SPEED: follow = U_IV0;
          ACT_MODE:  follow = U_MODE;
          ACT_MOVE:  follow = sts.mv_skip ? U_IDLE : U_PSM;
          default:   follow = sts.sync_skip ? U_IDLE : U_ZPS;
        endcase
      end
      U_IV0: follow = U_PS0;
      U_PS0: follow = U_IV1;
      U_IV1: follow = U_SPD;
      U_PSM: follow = U_MV;
      U_MV:  follow = U_EN;
      U_EN:  follow = sts.qa_nz ? U_LPS : (sts.ra_nz ? U_LRA : U_L0);
      U_LPS: follow = U_BQA;
      U_BQA: begin
        if (sync) follow = sts.rem_nz ? U_ZLR : U_ZL0;
        else follow = sts.ra_nz ? U_LRA : U_L0;
      end
      U_LRA: follow = U_B1;
      U_B1:  follow = sync ? U_ZL0 : U_L0;
      U_L0:  follow = U_DIS;
      U_ZPS: follow = U_FPS;
      U_FPS: follow = U_ZV;
      U_ZV:  follow = U_FV;
      U_FV:  follow = U_ZEN;
      U_ZEN: follow = U_FEN;
      U_FEN: begin
        if (sts.both_zero) follow = sts.rem_nz ? U_ZLR : U_ZL0;
        else follow = sts.zv_gt_fv ? U_ZLPS : U_FLPS;
      end
      U_ZLPS: follow = U_FZ;
      U_FZ:   follow = U_FLQ;
      U_FLQ:  follow = U_BQA;
      U_FLPS: follow = U_ZF;
      U_ZF:   follow = U_ZLQ;
      U_ZLQ:  follow = U_BQB;
      U_BQB:  follow = sts.rem_nz ? U_ZLR : U_ZL0;
      U_ZLR:  follow = U_FLR;
      U_FLR:  follow = U_B1;
      U_ZL0:  follow = U_FL0;
      U_FL0:  follow = U_ZDIS;
      U_ZDIS: follow = U_FDIS;
      default: follow = U_IDLE;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    started_nxt   = started_r;
    cmd.load      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.emit      = 1'b0;
    cmd.uop       = state_r;
    if (state_r == U_IDLE) begin
      if (in_tvalid) begin
        cmd.load  = 1'b1;
        state_nxt = follow;
      end
    end else if (state_r == U_DEC) begin
      state_nxt = follow;
    end else if (is_div) begin
      if (!started_r) begin
        cmd.div_start = 1'b1;
        started_nxt   = 1'b1;
      end else if (sts.div_done) begin
        started_nxt = 1'b0;
        state_nxt   = follow;
      end
    end else if (sts.out_free) begin
      cmd.emit  = 1'b1;
      state_nxt = follow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= U_IDLE;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
    end
  end

  assign in_tready = state_r == U_IDLE;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free) else $error("result issued into a full output register");
  a_div_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !sts.div_done) else $error("divider finished one cycle after start");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == U_IDLE) |-> (!cmd.emit && !cmd.div_start))
    else $error("work issued while idle");
  a_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (started_r && is_div)) else $error("stray divider completion");

endmodule

@@ tb/testbench.sv @@
// testbench: checks the lens move planner against its own predictor over directed and random command streams
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lsmp_pkg::*;

  typedef struct {
    logic [1:0]  action;
    logic        motor;
    logic [15:0] amount;
    logic [15:0] focus_amount;
    logic        reverse;
    logic        brake;
    logic        sensor_enable;
  } lens_cmd_t;

  typedef struct {
    logic        kind;
    logic [5:0]  reg_address;
    logic [15:0] reg_data;
    logic [15:0] pulse_count;
    logic        last;
  } lens_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  lens_cmd_t cmd_queue[$];
  lens_op_t planned_ops[$];
  lens_op_t cmd_ops[$];
  int cmd_total = 0;
  int cmds_taken = 0;
  int errors = 0;

  logic [15:0] zoom_ctl = CTL_RESET;
  logic [15:0] focus_ctl = CTL_RESET;
  logic [11:0] zoom_ivl = '0;
  logic [11:0] focus_ivl = '0;

  lens_stepper_move_planner dut (.*);

  always #5 clk = ~clk;

  function automatic int unsigned frame_pulses(input logic [11:0] ivl);
    return (27000000 / (100 * int'(ivl) * 24)) & 32'hff;
  endfunction

  function automatic logic [15:0] low_byte(input logic [15:0] r, input int unsigned v);
    return (r & HI_MASK) | {8'h00, v[7:0]};
  endfunction

  function automatic void add_op(input logic kind, input logic [5:0] a, input logic [15:0] d,
                                 input int unsigned c);
    lens_op_t o;
    o.kind = kind;
    o.reg_address = a;
    o.reg_data = d;
    o.pulse_count = c[15:0];
    o.last = 1'b0;
    cmd_ops.push_back(o);
  endfunction

  function automatic void plan_command(input lens_cmd_t c);
    int unsigned rate, iv, ps, micro, frames, left;
    int unsigned zps, fps, zmic, fmic, zv, fv, zl, fl;
    logic [5:0] caddr;
    logic [15:0] ctl;
    cmd_ops.delete();
    caddr = c.motor ? ADDR_FCTL : ADDR_ZCTL;
    ctl = c.motor ? focus_ctl : zoom_ctl;
    case (c.action)
      ACT_SPEED: begin
        rate = 32'(c.amount);
        if (rate < 100) rate = 100;
        if (rate > 3000) rate = 3000;
        iv = (27000000 * (c.motor ? 8 : 4)) / (rate * 768);
        ps = (27000000 / (100 * iv * 24)) & 32'hff;
        iv = (27000000 / (100 * ps * 24)) & 32'hfff;
        if (c.motor) focus_ivl = iv[11:0];
        else zoom_ivl = iv[11:0];
        add_op(1'b0, c.motor ? ADDR_FSPD : ADDR_ZSPD, iv[15:0], 0);
      end
      ACT_MODE: begin
        ctl = (ctl & ~MODE_MASK) | {4'b0, c.sensor_enable, 1'b0, c.brake, c.reverse, 8'h00};
        add_op(1'b0, caddr, ctl, 0);
      end
      ACT_MOVE: begin
        if (c.amount != 0 && (c.motor ? focus_ivl : zoom_ivl) != 0) begin
          ps = frame_pulses(c.motor ? focus_ivl : zoom_ivl);
          micro = c.amount * (c.motor ? 4 : 8);
          frames = micro / ps;
          left = micro % ps;
          ctl = ctl | EN_BIT;
          add_op(1'b0, caddr, ctl, 0);
          if (frames != 0) begin
            ctl = low_byte(ctl, ps);
            add_op(1'b0, caddr, ctl, 0);
            add_op(1'b1, 6'd0, 16'd0, frames);
          end
          if (left != 0) begin
            ctl = low_byte(ctl, left);
            add_op(1'b0, caddr, ctl, 0);
            add_op(1'b1, 6'd0, 16'd0, 1);
          end
          ctl = low_byte(ctl, 0);
          add_op(1'b0, caddr, ctl, 0);
          ctl = ctl & ~EN_BIT;
          add_op(1'b0, caddr, ctl, 0);
        end
      end
      default: begin
        if (zoom_ivl != 0 && focus_ivl != 0 && (c.amount != 0 || c.focus_amount != 0)) begin
          zps = frame_pulses(zoom_ivl);
          fps = frame_pulses(focus_ivl);
          zmic = c.amount * 8;
          fmic = c.focus_amount * 4;
          zv = zmic / zps;
          zl = (zmic % zps) & 32'hff;
          fv = fmic / fps;
          fl = (fmic % fps) & 32'hff;
          zoom_ctl = zoom_ctl | EN_BIT;
          add_op(1'b0, ADDR_ZCTL, zoom_ctl, 0);
          focus_ctl = focus_ctl | EN_BIT;
          add_op(1'b0, ADDR_FCTL, focus_ctl, 0);
          if (zv == 0 && fv == 0) begin
          end else if (zv > fv) begin
            zoom_ctl = low_byte(zoom_ctl, zps);
            add_op(1'b0, ADDR_ZCTL, zoom_ctl, 0);
            fl = (fmic % zv) & 32'hff;
            focus_ctl = low_byte(focus_ctl, fmic / zv);
            add_op(1'b0, ADDR_FCTL, focus_ctl, 0);
            add_op(1'b1, 6'd0, 16'd0, zv);
          end else begin
            focus_ctl = low_byte(focus_ctl, fps);
            add_op(1'b0, ADDR_FCTL, focus_ctl, 0);
            zl = (zmic % fv) & 32'hff;
            zoom_ctl = low_byte(zoom_ctl, zmic / fv);
            add_op(1'b0, ADDR_ZCTL, zoom_ctl, 0);
            add_op(1'b1, 6'd0, 16'd0, fv);
          end
          if (zl != 0 || fl != 0) begin
            zoom_ctl = low_byte(zoom_ctl, zl);
            add_op(1'b0, ADDR_ZCTL, zoom_ctl, 0);
            focus_ctl = low_byte(focus_ctl, fl);
            add_op(1'b0, ADDR_FCTL, focus_ctl, 0);
            add_op(1'b1, 6'd0, 16'd0, 1);
          end
          zoom_ctl = low_byte(zoom_ctl, 0);
          add_op(1'b0, ADDR_ZCTL, zoom_ctl, 0);
          focus_ctl = low_byte(focus_ctl, 0);
          add_op(1'b0, ADDR_FCTL, focus_ctl, 0);
          zoom_ctl = zoom_ctl & ~EN_BIT;
          add_op(1'b0, ADDR_ZCTL, zoom_ctl, 0);
          focus_ctl = focus_ctl & ~EN_BIT;
          add_op(1'b0, ADDR_FCTL, focus_ctl, 0);
        end
      end
    endcase
    if (c.action == ACT_MODE || c.action == ACT_MOVE) begin
      if (c.action == ACT_MODE || cmd_ops.size() != 0) begin
        if (c.motor) focus_ctl = ctl;
        else zoom_ctl = ctl;
      end
    end
    if (cmd_ops.size() != 0) cmd_ops[cmd_ops.size()-1].last = 1'b1;
    foreach (cmd_ops[i]) planned_ops.push_back(cmd_ops[i]);
  endfunction

  function automatic int idle_pct(input bit sender);
    int phase;
    phase = (cmd_total == 0) ? 2 : (cmds_taken * 3) / cmd_total;
    if (phase == 0) return sender ? 21 : 73;
    if (phase == 1) return sender ? 73 : 21;
    return 0;
  endfunction

  // command driver
  always @(posedge clk) begin
    lens_cmd_t c;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        c.motor = in_tdata[0];
        c.amount = in_tdata[16:1];
        c.focus_amount = in_tdata[32:17];
        c.reverse = in_tdata[33];
        c.brake = in_tdata[34];
        c.sensor_enable = in_tdata[35];
        c.action = in_tuser;
        plan_command(c);
        cmds_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          c = cmd_queue.pop_front();
          in_tdata <= {4'b0, c.sensor_enable, c.brake, c.reverse, c.focus_amount,
                       c.amount, c.motor};
          in_tuser <= c.action;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    lens_op_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (planned_ops.size() == 0) begin
          $error("unexpected transaction tdata=%h", out_tdata);
          errors++;
        end else begin
          e = planned_ops.pop_front();
          if (out_tuser !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, out_tuser); errors++;
          end
          if (out_tdata[5:0] !== e.reg_address) begin
            $error("reg_address exp %h got %h", e.reg_address, out_tdata[5:0]); errors++;
          end
          if (out_tdata[21:6] !== e.reg_data) begin
            $error("reg_data exp %h got %h", e.reg_data, out_tdata[21:6]); errors++;
          end
          if (out_tdata[37:22] !== e.pulse_count) begin
            $error("pulse_count exp %0d got %0d", e.pulse_count, out_tdata[37:22]); errors++;
          end
          if (out_tlast !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_tlast); errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  function automatic lens_cmd_t make_cmd(input logic [1:0] act, input logic m,
                                         input logic [15:0] a, input logic [15:0] f);
    lens_cmd_t c;
    c.action = act;
    c.motor = m;
    c.amount = a;
    c.focus_amount = f;
    c.reverse = 1'($urandom_range(1));
    c.brake = 1'($urandom_range(1));
    c.sensor_enable = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic logic [15:0] rand_steps();
    int r;
    r = $urandom_range(9);
    if (r < 2) return 16'($urandom_range(0, 3));
    if (r < 8) return 16'($urandom_range(1, 300));
    return 16'($urandom);
  endfunction

  initial begin
    lens_cmd_t c;
    int r;
    // speed not set yet
    cmd_queue.push_back(make_cmd(ACT_MOVE, 1'b0, 16'd50, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_SYNC, 1'b0, 16'd50, 16'd40));
    cmd_queue.push_back(make_cmd(ACT_SPEED, 1'b0, 16'd0, 16'hffff));
    cmd_queue.push_back(make_cmd(ACT_SYNC, 1'b0, 16'd50, 16'd40));
    cmd_queue.push_back(make_cmd(ACT_SPEED, 1'b1, 16'hffff, 16'h0000));
    cmd_queue.push_back(make_cmd(ACT_SPEED, 1'b0, 16'd3000, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_SPEED, 1'b1, 16'd100, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_SPEED, 1'b0, 16'd99, 16'd0));
    c = make_cmd(ACT_MODE, 1'b0, 16'hffff, 16'hffff);
    c.reverse = 1'b1; c.brake = 1'b1; c.sensor_enable = 1'b1;
    cmd_queue.push_back(c);
    c = make_cmd(ACT_MODE, 1'b1, 16'd0, 16'd0);
    c.reverse = 1'b0; c.brake = 1'b0; c.sensor_enable = 1'b0;
    cmd_queue.push_back(c);
    cmd_queue.push_back(make_cmd(ACT_MOVE, 1'b0, 16'd0, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_MOVE, 1'b0, 16'd1, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_MOVE, 1'b1, 16'd7, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_MOVE, 1'b0, 16'hffff, 16'hffff));
    cmd_queue.push_back(make_cmd(ACT_MOVE, 1'b1, 16'hffff, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_SYNC, 1'b0, 16'd0, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_SYNC, 1'b1, 16'd1, 16'd1));
    cmd_queue.push_back(make_cmd(ACT_SYNC, 1'b0, 16'd900, 16'd5));
    cmd_queue.push_back(make_cmd(ACT_SYNC, 1'b0, 16'd5, 16'd900));
    cmd_queue.push_back(make_cmd(ACT_SPEED, 1'b1, 16'd3000, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_SYNC, 1'b1, 16'hffff, 16'd3));
    cmd_queue.push_back(make_cmd(ACT_SYNC, 1'b0, 16'd2, 16'hffff));
    cmd_queue.push_back(make_cmd(ACT_SYNC, 1'b0, 16'd0, 16'd700));
    repeat (87) begin
      r = $urandom_range(99);
      if (r < 20)
        c = make_cmd(ACT_SPEED, 1'($urandom_range(1)),
                     ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3200)),
                     16'($urandom));
      else if (r < 35)
        c = make_cmd(ACT_MODE, 1'($urandom_range(1)), 16'($urandom), 16'($urandom));
      else if (r < 65)
        c = make_cmd(ACT_MOVE, 1'($urandom_range(1)), rand_steps(), 16'($urandom));
      else
        c = make_cmd(ACT_SYNC, 1'($urandom_range(1)), rand_steps(), rand_steps());
      cmd_queue.push_back(c);
    end
    cmd_total = cmd_queue.size();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (cmd_queue.size() == 0 && !in_tvalid);
    wait (planned_ops.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && planned_ops.size() == 0) begin
      $display("lens_stepper_move_planner regression: pass");
    end else begin
      $display("lens_stepper_move_planner regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("lens_stepper_move_planner regression: fail");
    $finish;
  end
endmodule
